/* design/rsq_pkg.sv */
// Shared constants and controller/datapath interface types for the reservoir sampler.
`timescale 1ns / 1ps
`default_nettype none
package rsq_pkg;
   localparam int SAMPLES_DEF = 64;
   localparam int VAL_W       = 32;
   localparam int RAND_W      = 31;
   localparam int FRAC_W      = 18;
   localparam int CNT_W       = 32;
   localparam int DIV_STEPS   = 31;
   localparam int REQ_DATA_W  = 112;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      RD_I   = 2'd0,
      RD_JM1 = 2'd1,
      RD_IDX = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       wr_direct;
      logic       div_start;
      logic       div_step;
      logic       div_write;
      logic       sort_init;
      logic       ld_v;
      rd_sel_type rd_sel;
      logic       rd_en;
      logic       shift_wr;
      logic       put_wr;
      logic       i_inc;
      logic       j_dec;
      logic       out_load;
      logic       empty_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic count_lt;
      logic filled_zero;
      logic filled_one;
      logic div_done;
      logic less;
      logic j_one;
      logic i_last;
   } status_type;
endpackage
`default_nettype wire

/* design/rsq_ctrl.sv */
// Sequencer for insert, serial modulo, insertion sort and quantile readout.
`timescale 1ns / 1ps
`default_nettype none
module rsq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire rsq_pkg::status_type st,
   output rsq_pkg::cmd_type        cmd
);
   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DIV     = 9'b000000010,
      S_SRT_RDI = 9'b000000100,
      S_SRT_LDV = 9'b000001000,
      S_SRT_RDP = 9'b000010000,
      S_SRT_CMP = 9'b000100000,
      S_SRT_PUT = 9'b001000000,
      S_SEL     = 9'b010000000,
      S_OUT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ld_ff, sel_ld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ld_ff <= sel_ld_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      state_in  = state_ff;
      sel_ld_in = 1'b0;
      cmd       = '0;
      cmd.rd_sel = rsq_pkg::RD_I;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // Query decisions use the count as it stands before this beat.
               if (st.is_query == rsq_pkg::ACT_INSERT) begin
                  if (st.count_lt) begin
                     cmd.wr_direct = 1'b1;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end else if (st.filled_zero) begin
                  cmd.empty_load = 1'b1;
                  state_in       = S_OUT;
               end else if (st.filled_one) begin
                  state_in = S_SEL;
               end else begin
                  cmd.sort_init = 1'b1;
                  state_in      = S_SRT_RDI;
               end
            end
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.div_write = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_SRT_RDI: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = rsq_pkg::RD_I;
            state_in   = S_SRT_LDV;
         end
         S_SRT_LDV: begin
            cmd.ld_v = 1'b1;
            state_in = S_SRT_RDP;
         end
         S_SRT_RDP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = rsq_pkg::RD_JM1;
            state_in   = S_SRT_CMP;
         end
         S_SRT_CMP: begin
            if (st.less) begin
               cmd.shift_wr = 1'b1;
               cmd.j_dec    = 1'b1;
               state_in     = st.j_one ? S_SRT_PUT : S_SRT_RDP;
            end else begin
               cmd.put_wr = 1'b1;
               // The insert index stops on the last entry instead of wrapping.
               cmd.i_inc  = !st.i_last;
               state_in   = st.i_last ? S_SEL : S_SRT_RDI;
            end
         end
         S_SRT_PUT: begin
            cmd.put_wr = 1'b1;
            cmd.i_inc  = !st.i_last;
            state_in   = st.i_last ? S_SEL : S_SRT_RDI;
         end
         S_SEL: begin
            // The chosen entry is read first, then captured into the output register.
            if (!sel_ld_ff) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = rsq_pkg::RD_IDX;
               sel_ld_in  = 1'b1;
            end else begin
               cmd.out_load = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

/* design/rsq_dp.sv */
// Datapath: sample memory, seen counter, serial remainder unit, sort registers, output.
`timescale 1ns / 1ps
`default_nettype none
module rsq_dp #(
   parameter int SAMPLES = rsq_pkg::SAMPLES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_action,
   input  wire logic [rsq_pkg::VAL_W-1:0]     req_sample_value,
   input  wire logic [rsq_pkg::RAND_W-1:0]    req_accept_random,
   input  wire logic [rsq_pkg::RAND_W-1:0]    req_slot_random,
   input  wire logic [rsq_pkg::FRAC_W-1:0]    req_fraction,
   input  wire rsq_pkg::cmd_type              cmd,
   output rsq_pkg::status_type                st,
   output logic [rsq_pkg::VAL_W-1:0]          rsp_quantile_value,
   output logic                               rsp_empty_res
);
   localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int CW = $clog2(SAMPLES + 1);
   localparam int SW = $clog2(rsq_pkg::DIV_STEPS + 1);
   localparam logic [rsq_pkg::CNT_W-1:0] SAMP_C = rsq_pkg::CNT_W'(SAMPLES);
   localparam logic [CW-1:0] SAMP_N = CW'(SAMPLES);

   logic [rsq_pkg::VAL_W-1:0]  mem [SAMPLES];
   logic [rsq_pkg::VAL_W-1:0]  rdata_ff;
   logic [rsq_pkg::CNT_W-1:0]  seen_ff, seen_in;
   logic                       action_ff;
   logic [rsq_pkg::VAL_W-1:0]  value_ff;
   logic [rsq_pkg::FRAC_W-1:0] frac_ff;
   logic [rsq_pkg::RAND_W-1:0] acc_sh_ff, slot_sh_ff;
   logic [rsq_pkg::CNT_W-1:0]  divisor_ff, rem_a_ff, rem_a_in;
   logic [CW-1:0]              rem_s_ff, rem_s_in;
   logic [SW-1:0]              dcnt_ff;
   logic [AW-1:0]              i_ff, j_ff;
   logic [rsq_pkg::VAL_W-1:0]  v_ff;
   logic [rsq_pkg::VAL_W-1:0]  out_ff;
   logic                       empty_ff;
   logic [CW-1:0]              filled;
   logic [AW-1:0]              idx, raddr, waddr;
   logic [rsq_pkg::VAL_W-1:0]  wdata;
   logic                       wen;
   logic [rsq_pkg::CNT_W:0]    t_a;
   logic [CW:0]                t_s;
   logic [16+CW-1:0]           prod;

   assign filled = (seen_ff < SAMP_C) ? seen_ff[CW-1:0] : SAMP_N;
   assign seen_in = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;

   // One restoring step per cycle for both remainders.
   assign t_a      = {rem_a_ff, acc_sh_ff[rsq_pkg::RAND_W-1]};
   assign rem_a_in = (t_a >= {1'b0, divisor_ff}) ? rsq_pkg::CNT_W'(t_a - {1'b0, divisor_ff})
                                                 : t_a[rsq_pkg::CNT_W-1:0];
   assign t_s      = {rem_s_ff, slot_sh_ff[rsq_pkg::RAND_W-1]};
   assign rem_s_in = (t_s >= {1'b0, SAMP_N}) ? CW'(t_s - {1'b0, SAMP_N}) : t_s[CW-1:0];

   assign prod = frac_ff[15:0] * filled;
   always_comb begin
      if (frac_ff[rsq_pkg::FRAC_W-1]) begin
         idx = '0;
      end else if (frac_ff[16]) begin
         idx = AW'(filled - 1'b1);
      end else begin
         idx = AW'(prod >> 16);
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         rsq_pkg::RD_I:   raddr = i_ff;
         rsq_pkg::RD_JM1: raddr = j_ff - 1'b1;
         rsq_pkg::RD_IDX: raddr = idx;
         default:         raddr = i_ff;
      endcase
   end

   always_comb begin
      wen   = 1'b0;
      waddr = j_ff;
      wdata = v_ff;
      if (cmd.wr_direct) begin
         wen   = 1'b1;
         waddr = seen_ff[AW-1:0];
         wdata = req_sample_value;
      end else if (cmd.div_write) begin
         wen   = (rem_a_ff < SAMP_C);
         waddr = rem_s_ff[AW-1:0];
         wdata = value_ff;
      end else if (cmd.shift_wr) begin
         wen   = 1'b1;
         wdata = rdata_ff;
      end else if (cmd.put_wr) begin
         wen = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.load && req_action == rsq_pkg::ACT_INSERT) begin
            seen_ff <= seen_in;
         end
         if (cmd.div_start) begin
            dcnt_ff <= '0;
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         if (cmd.sort_init) begin
            i_ff <= AW'(1);
            j_ff <= '0;
         end else begin
            if (cmd.i_inc) begin
               i_ff <= i_ff + 1'b1;
            end
            if (cmd.ld_v) begin
               j_ff <= i_ff;
            end else if (cmd.j_dec) begin
               j_ff <= j_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_sample_value;
         frac_ff  <= req_fraction;
      end
      if (cmd.div_start) begin
         acc_sh_ff  <= req_accept_random;
         slot_sh_ff <= req_slot_random;
         divisor_ff <= seen_in;
         rem_a_ff   <= '0;
         rem_s_ff   <= '0;
      end else if (cmd.div_step) begin
         acc_sh_ff  <= acc_sh_ff << 1;
         slot_sh_ff <= slot_sh_ff << 1;
         rem_a_ff   <= rem_a_in;
         rem_s_ff   <= rem_s_in;
      end
      if (cmd.ld_v) begin
         v_ff <= rdata_ff;
      end
      if (cmd.out_load) begin
         out_ff   <= rdata_ff;
         empty_ff <= 1'b0;
      end else if (cmd.empty_load) begin
         out_ff   <= '0;
         empty_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         action_ff <= rsq_pkg::ACT_INSERT;
      end else if (cmd.load) begin
         action_ff <= req_action;
      end
   end

   assign st.is_query    = req_action;
   assign st.count_lt    = (seen_ff < SAMP_C);
   assign st.filled_zero = (filled == '0);
   assign st.filled_one  = (filled == CW'(1));
   assign st.div_done    = (dcnt_ff == SW'(rsq_pkg::DIV_STEPS));
   assign st.less        = ($signed(v_ff) < $signed(rdata_ff));
   assign st.j_one       = (j_ff == AW'(1));
   assign st.i_last      = (CW'(i_ff) == CW'(filled - 1'b1));

   assign rsp_quantile_value = out_ff;
   assign rsp_empty_res      = empty_ff;

`ifndef SYNTHESIS
   a_seen_mono: assert property (@(posedge clock) disable iff (reset)
      seen_ff >= $past(seen_ff)) else $error("seen count went backward");
   a_j_le_i: assert property (@(posedge clock) disable iff (reset)
      j_ff <= i_ff) else $error("sort hole index passed insert index");
   a_direct_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_direct |-> (req_action == rsq_pkg::ACT_INSERT))
      else $error("fill write on a query beat");
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.div_write |-> (action_ff == rsq_pkg::ACT_INSERT))
      else $error("insert write during a query");
`endif
endmodule
`default_nettype wire

/* design/reservoir_sampler_quantile_unit.sv */
// Top level of the reservoir sampler with quantile query.
`timescale 1ns / 1ps
`default_nettype none
// Algorithm R reservoir of SAMPLES signed Q16.16 values in one memory with
// a read and a write port. An insert while the reservoir fills is written
// directly; once it is full an insert runs the serial remainder unit that
// reduces accept_random by the seen count and slot_random by SAMPLES, one
// bit a cycle. A query with two or more filled entries runs an in-place
// insertion sort through the memory port, then reads the chosen entry; the
// result is held on the rsp side until taken, and no new beat is accepted
// meanwhile.
module reservoir_sampler_quantile_unit #(
   parameter int SAMPLES = rsq_pkg::SAMPLES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // sample_value[31:0], accept_random[62:32], slot_random[93:63], fraction[111:94]
   input  wire logic [rsq_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // quantile_value[31:0]
   output logic [rsq_pkg::VAL_W-1:0]           rsp_tdata,
   // empty_res[0]
   output logic                                rsp_tuser
);
   rsq_pkg::cmd_type    cmd;
   rsq_pkg::status_type st;

   rsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   rsq_dp #(
      .SAMPLES (SAMPLES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_tuser),
      .req_sample_value   (req_tdata[31:0]),
      .req_accept_random  (req_tdata[62:32]),
      .req_slot_random    (req_tdata[93:63]),
      .req_fraction       (req_tdata[111:94]),
      .cmd                (cmd),
      .st                 (st),
      .rsp_quantile_value (rsp_tdata),
      .rsp_empty_res      (rsp_tuser)
   );
endmodule
`default_nettype wire
